@@ hdl/trdt_pkg.sv @@
// Package for the trimmed range block: data widths, chain depth, count limit,
// shared types. No dependencies.
package trdt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int KEEP       = 4;
  localparam int CNT_W      = 3;

  localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(5);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic        [DATA_WIDTH-1:0] udata_t;
  typedef data_t [KEEP-1:0]             row_t;
  typedef udata_t [KEEP-1:0]            urow_t;

  localparam data_t VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic en;
    logic clear;
  } chain_ctl_t;

endpackage

@@ hdl/trimmed_range_drop_three.sv @@
// Top level of the trimmed range block: two insertion chains, sample count,
// spread pipeline. Depends on trdt_pkg, trdt_chain and trdt_spread.
//
// Accepts one sample per clock. Each sample enters two four-cell insertion
// chains (largest values, and smallest values held complemented) in the cycle
// it is accepted; the chains and the count clear after a last_of_set
// transaction. That transaction yields one spread through a difference
// stage, a minimum stage and the output register. in_ready drops only
// while the difference stage holds a result that the stalled stages behind
// it cannot take; otherwise a sample is taken every cycle, including while
// a finished spread waits on out_ready.
module trimmed_range_drop_three (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  trdt_pkg::data_t     in_sample,
  input  logic                in_last_of_set,
  output logic                out_valid,
  input  logic                out_ready,
  output trdt_pkg::udata_t    out_spread
);
  import trdt_pkg::*;

  logic             acc;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  chain_ctl_t       ctl;
  row_t             lg_vals, lg_nxt, smc_vals, smc_nxt, sm_nxt;

  assign acc       = in_valid && in_ready;
  assign ctl.en    = acc;
  assign ctl.clear = in_last_of_set;
  assign cnt_nxt   = (cnt_r == COUNT_SAT) ? cnt_r : cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc) begin
      cnt_r <= in_last_of_set ? '0 : cnt_nxt;
    end
  end

  trdt_chain u_lg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .v        (in_sample),
    .vals     (lg_vals),
    .vals_nxt (lg_nxt)
  );

  trdt_chain u_sm (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .v        (~in_sample),
    .vals     (smc_vals),
    .vals_nxt (smc_nxt)
  );

  for (genvar j = 0; j < KEEP; j++) begin : g_sm
    assign sm_nxt[j] = ~smc_nxt[j];
  end

  trdt_spread u_spread (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (acc && in_last_of_set),
    .in_ready   (in_ready),
    .full       (cnt_nxt == COUNT_SAT),
    .lg         (lg_nxt),
    .sm         (sm_nxt),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_spread (out_spread)
  );

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last_of_set) |=> (cnt_r == '0))
    else $error("sample count not cleared after last transaction");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_SAT)
    else $error("sample count beyond saturation");

  for (genvar i = 0; i < KEEP-1; i++) begin : g_order
    a_lg_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      lg_vals[i] >= lg_vals[i+1])
      else $error("largest chain out of order");
    a_sm_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      smc_vals[i] >= smc_vals[i+1])
      else $error("smallest chain out of order");
  end

endmodule

@@ hdl/trdt_cell.sv @@
// One cell of a descending insertion chain: holds one tracked value.
// Depends on trdt_pkg.
module trdt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  trdt_pkg::chain_ctl_t ctl,
  input  trdt_pkg::data_t    v,
  input  logic               up_gt,
  input  trdt_pkg::data_t    up_val,
  output logic               gt,
  output trdt_pkg::data_t    val,
  output trdt_pkg::data_t    val_nxt
);
  import trdt_pkg::*;

  data_t val_r;

  assign gt      = v > val_r;
  assign val_nxt = gt ? (up_gt ? up_val : v) : val_r;
  assign val     = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (ctl.en && ctl.clear)) begin
      val_r <= VAL_MIN;
    end else if (ctl.en) begin
      val_r <= val_nxt;
    end
  end

endmodule

@@ hdl/trdt_chain.sv @@
// Row of insertion cells keeping the largest values in descending order.
// Depends on trdt_pkg and trdt_cell.
module trdt_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  trdt_pkg::chain_ctl_t ctl,
  input  trdt_pkg::data_t      v,
  output trdt_pkg::row_t       vals,
  output trdt_pkg::row_t       vals_nxt
);
  import trdt_pkg::*;

  logic [KEEP:0] gt_c;
  data_t         up_c [KEEP+1];

  assign gt_c[0] = 1'b0;
  assign up_c[0] = VAL_MIN;

  for (genvar i = 0; i < KEEP; i++) begin : g_cell
    trdt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .v       (v),
      .up_gt   (gt_c[i]),
      .up_val  (up_c[i]),
      .gt      (gt_c[i+1]),
      .val     (vals[i]),
      .val_nxt (vals_nxt[i])
    );
    assign up_c[i+1] = vals[i];
  end

endmodule

@@ hdl/trdt_spread.sv @@
// Spread pipeline: pairwise differences, then a two-level minimum, then the
// output register. Depends on trdt_pkg.
module trdt_spread (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             full,
  input  trdt_pkg::row_t   lg,
  input  trdt_pkg::row_t   sm,
  output logic             out_valid,
  input  logic             out_ready,
  output trdt_pkg::udata_t out_spread
);
  import trdt_pkg::*;

  function automatic udata_t min2(udata_t a, udata_t b);
    return (b < a) ? b : a;
  endfunction

  logic   s1_v_r, s2_v_r, out_v_r;
  logic   s1_rdy, s2_rdy, o_rdy;
  urow_t  d_r;
  udata_t m0_r, m1_r, spread_r;

  assign o_rdy    = !out_v_r || out_ready;
  assign s2_rdy   = !s2_v_r || o_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (o_rdy)  out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      for (int k = 0; k < KEEP; k++) begin
        d_r[k] <= full ? (udata_t'(lg[k]) - udata_t'(sm[KEEP-1-k])) : '0;
      end
    end
    if (s2_rdy && s1_v_r) begin
      m0_r <= min2(d_r[0], d_r[1]);
      m1_r <= min2(d_r[2], d_r[3]);
    end
    if (o_rdy && s2_v_r) begin
      spread_r <= min2(m0_r, m1_r);
    end
  end

  assign out_valid  = out_v_r;
  assign out_spread = spread_r;

endmodule
